// ----- rtl/cir_pkg.sv -----
package cir_pkg;

    localparam int CW   = 21;
    localparam int NW   = 16;
    localparam int PW   = CW + NW + 1;
    localparam int VNW  = PW + 2;
    localparam int NEGW = VNW - 1;
    localparam int KW   = 11;
    localparam int MW   = 24;
    localparam int BW   = 9;
    localparam int CFW  = 9;
    localparam int PENW = 20;
    localparam int CMW  = PENW + CFW;
    localparam int JW   = 37;
    localparam int DNW  = MW + 1;
    localparam int DVW  = JW + DNW;
    localparam int RW   = JW + NW - 22;
    localparam int SW   = RW + 2;
    localparam int LAT  = JW + 6;

    localparam logic [CFW-1:0]      CF_RESET = 9'd205;
    localparam logic signed [SW-1:0] SMAX    = SW'((1 << (CW - 1)) - 1);
    localparam logic signed [SW-1:0] SMIN    = -SMAX - SW'(1);

    typedef enum logic [1:0] {
        OC_STATIC     = 2'd0,
        OC_SEPARATING = 2'd1,
        OC_RESOLVED   = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [3*NW-1:0] n;
        logic [3*CW-1:0] v1;
        logic [3*CW-1:0] v2;
        logic [3*CW-1:0] p1;
        logic [3*CW-1:0] p2;
        t_outcome        outcome;
    } t_side;

    typedef struct packed {
        logic [JW-1:0] j1;
        logic [JW-1:0] j2;
        logic [JW-1:0] c1;
        logic [JW-1:0] c2;
    } t_share;

    function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] x);
        if (x > SMAX) begin
            return SMAX[CW-1:0];
        end else if (x < SMIN) begin
            return SMIN[CW-1:0];
        end else begin
            return x[CW-1:0];
        end
    endfunction

endpackage

// ----- rtl/cir_dot_lane.sv -----
module cir_dot_lane (
    input  logic                             i_clk,
    input  logic signed [cir_pkg::CW-1:0]    i_v1,
    input  logic signed [cir_pkg::CW-1:0]    i_v2,
    input  logic signed [cir_pkg::NW-1:0]    i_n,
    output logic signed [cir_pkg::PW-1:0]    o_prod
);

    logic signed [cir_pkg::CW:0]   w_dv;
    logic signed [cir_pkg::PW-1:0] r_prod;

    assign w_dv = (cir_pkg::CW + 1)'(i_v2) - (cir_pkg::CW + 1)'(i_v1);

    always_ff @(posedge i_clk) begin
        r_prod <= w_dv * i_n;
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/cir_div_pipe.sv -----
module cir_div_pipe #(
    parameter int DVW = cir_pkg::DVW,
    parameter int DNW = cir_pkg::DNW,
    parameter int QW  = cir_pkg::JW
) (
    input  logic           i_clk,
    input  logic [DVW-1:0] i_dividend,
    input  logic [DNW-1:0] i_divisor,
    output logic [QW-1:0]  o_quot
);

    logic [DVW-1:0] r_rem [QW];
    logic [DNW-1:0] r_den [QW];
    logic [QW-1:0]  r_q   [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic [DVW-1:0] w_rem_in;
        logic [DVW-1:0] w_sub;
        logic [DNW-1:0] w_den_in;
        logic [QW-1:0]  w_q_in;
        logic           w_take;

        if (s == 0) begin : g_first
            assign w_rem_in = i_dividend;
            assign w_den_in = i_divisor;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_sub  = DVW'(w_den_in) << B;
        assign w_take = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_take ? (w_rem_in - w_sub) : w_rem_in;
            r_den[s] <= w_den_in;
            r_q[s]   <= w_take ? (w_q_in | (QW'(1) << B)) : w_q_in;
        end
    end

    assign o_quot = r_q[QW-1];

endmodule

// ----- rtl/cir_upd_lane.sv -----
module cir_upd_lane (
    input  logic                           i_clk,
    input  logic signed [cir_pkg::NW-1:0]  i_n,
    input  logic signed [cir_pkg::CW-1:0]  i_v1,
    input  logic signed [cir_pkg::CW-1:0]  i_v2,
    input  logic signed [cir_pkg::CW-1:0]  i_p1,
    input  logic signed [cir_pkg::CW-1:0]  i_p2,
    input  cir_pkg::t_share                i_share,
    output logic [cir_pkg::CW-1:0]         o_v1,
    output logic [cir_pkg::CW-1:0]         o_v2,
    output logic [cir_pkg::CW-1:0]         o_p1,
    output logic [cir_pkg::CW-1:0]         o_p2
);

    localparam int PRW = cir_pkg::JW + cir_pkg::NW;

    function automatic logic [cir_pkg::RW-1:0] rnd(
        input logic [cir_pkg::JW-1:0] m,
        input logic [cir_pkg::NW-1:0] a,
        input int                     sh
    );
        logic [PRW-1:0] p;
        p = PRW'(m) * PRW'(a) + (PRW'(1) << (sh - 1));
        p = p >> sh;
        return p[cir_pkg::RW-1:0];
    endfunction

    function automatic logic [cir_pkg::CW-1:0] apply(
        input logic signed [cir_pkg::CW-1:0] base,
        input logic [cir_pkg::RW-1:0]        mag,
        input logic                          neg,
        input logic                          sub
    );
        logic signed [cir_pkg::SW-1:0] d;
        logic signed [cir_pkg::SW-1:0] x;
        d = $signed({2'b00, mag});
        if (neg ^ sub) begin
            d = -d;
        end
        x = cir_pkg::SW'(base) + d;
        return cir_pkg::sat(x);
    endfunction

    logic                          w_neg;
    logic [cir_pkg::NW-1:0]        w_an;
    logic [cir_pkg::RW-1:0]        r_mj1, r_mj2, r_mc1, r_mc2;
    logic                          r_neg;
    logic signed [cir_pkg::CW-1:0] r_v1, r_v2, r_p1, r_p2;
    logic [cir_pkg::CW-1:0]        r_v1n, r_v2n, r_p1n, r_p2n;

    assign w_neg = i_n[cir_pkg::NW-1];
    assign w_an  = w_neg ? cir_pkg::NW'(-i_n) : cir_pkg::NW'(i_n);

    always_ff @(posedge i_clk) begin
        r_mj1 <= rnd(i_share.j1, w_an, 24);
        r_mj2 <= rnd(i_share.j2, w_an, 24);
        r_mc1 <= rnd(i_share.c1, w_an, 22);
        r_mc2 <= rnd(i_share.c2, w_an, 22);
        r_neg <= w_neg;
        r_v1  <= i_v1;
        r_v2  <= i_v2;
        r_p1  <= i_p1;
        r_p2  <= i_p2;
    end

    always_ff @(posedge i_clk) begin
        r_v1n <= apply(r_v1, r_mj1, r_neg, 1'b1);
        r_v2n <= apply(r_v2, r_mj2, r_neg, 1'b0);
        r_p1n <= apply(r_p1, r_mc1, r_neg, 1'b1);
        r_p2n <= apply(r_p2, r_mc2, r_neg, 1'b0);
    end

    assign o_v1 = r_v1n;
    assign o_v2 = r_v2n;
    assign o_p1 = r_p1n;
    assign o_p2 = r_p2n;

endmodule

// ----- rtl/contact_impulse_resolver_core.sv -----
// o_valid marks the result beat of each accepted contact.
// Throughput: one contact per cycle; busy is never raised.
// Most of the latency lies in the 37-stage restoring divider pipelines that share
// impulse and correction by inverse mass; the result cannot be stalled.
// Reset (synchronous, active low) empties the pipeline and loads the
// correction fraction with 205; the datapath registers are not reset.
module contact_impulse_resolver_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [cir_pkg::CFW-1:0]           i_cfg_wdata,
    input  logic [3*cir_pkg::NW-1:0]          i_contact_normal,
    input  logic [cir_pkg::PENW-1:0]          i_penetration_depth,
    input  logic [3*cir_pkg::CW-1:0]          i_velocity_first,
    input  logic [3*cir_pkg::CW-1:0]          i_velocity_second,
    input  logic [3*cir_pkg::CW-1:0]          i_position_first,
    input  logic [3*cir_pkg::CW-1:0]          i_position_second,
    input  logic [cir_pkg::MW-1:0]            i_mass_first,
    input  logic [cir_pkg::MW-1:0]            i_mass_second,
    input  logic [cir_pkg::BW-1:0]            i_bounce_first,
    input  logic [cir_pkg::BW-1:0]            i_bounce_second,
    input  logic                              i_fixed_first,
    input  logic                              i_fixed_second,
    output logic                              o_valid,
    output logic [3*cir_pkg::CW-1:0]          o_new_velocity_first,
    output logic [3*cir_pkg::CW-1:0]          o_new_velocity_second,
    output logic [3*cir_pkg::CW-1:0]          o_new_position_first,
    output logic [3*cir_pkg::CW-1:0]          o_new_position_second,
    output logic [1:0]                        o_outcome
);

    localparam int CW  = cir_pkg::CW;
    localparam int NW  = cir_pkg::NW;
    localparam int JW  = cir_pkg::JW;
    localparam int DNW = cir_pkg::DNW;
    localparam int DVW = cir_pkg::DVW;
    localparam int LAT = cir_pkg::LAT;
    localparam int JPW = cir_pkg::NEGW + cir_pkg::KW;

    logic                          w_acc;
    logic [cir_pkg::CFW-1:0]       r_cf;
    logic [LAT-1:0]                r_vld;

    logic signed [cir_pkg::PW-1:0] w_prod [3];
    cir_pkg::t_side                r_s1_side, r_s2_side, r_s3_side, r_s4_side;
    logic [cir_pkg::PENW-1:0]      r_s1_pen;
    logic [cir_pkg::MW-1:0]        r_s1_m1, r_s1_m2, r_s2_m1, r_s2_m2;
    logic [cir_pkg::BW-1:0]        r_s1_b1, r_s1_b2;
    logic                          r_s1_st1, r_s1_st2, r_s2_st1, r_s2_st2;

    logic signed [cir_pkg::VNW-1:0] r_s2_vn;
    logic [cir_pkg::CMW-1:0]        r_s2_c;
    logic [cir_pkg::KW-1:0]         r_s2_k;

    logic                          w_res;
    logic [cir_pkg::VNW-1:0]       w_negvn;
    logic [JPW-1:0]                w_jfull;
    cir_pkg::t_outcome             w_oc;
    logic [JW-1:0]                 r_s3_j, r_s3_c;
    logic [DNW-1:0]                r_s3_num1, r_s3_num2, r_s3_den;

    logic [DVW-1:0]                r_s4_dj1, r_s4_dj2, r_s4_dc1, r_s4_dc2;
    logic [DNW-1:0]                r_s4_den;

    logic [JW-1:0]                 w_qj1, w_qj2, w_qc1, w_qc2;
    cir_pkg::t_share               w_share;
    cir_pkg::t_side                r_sd [JW];
    cir_pkg::t_outcome             r_oca, r_ocb;

    logic [CW-1:0] w_nv1 [3];
    logic [CW-1:0] w_nv2 [3];
    logic [CW-1:0] w_np1 [3];
    logic [CW-1:0] w_np2 [3];

    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf  <= cir_pkg::CF_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cf <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_dot
        cir_dot_lane u_dot (
            .i_clk  (i_clk),
            .i_v1   (i_velocity_first[a*CW +: CW]),
            .i_v2   (i_velocity_second[a*CW +: CW]),
            .i_n    (i_contact_normal[a*NW +: NW]),
            .o_prod (w_prod[a])
        );
    end

    always_ff @(posedge i_clk) begin
        r_s1_side.n       <= i_contact_normal;
        r_s1_side.v1      <= i_velocity_first;
        r_s1_side.v2      <= i_velocity_second;
        r_s1_side.p1      <= i_position_first;
        r_s1_side.p2      <= i_position_second;
        r_s1_side.outcome <= cir_pkg::OC_STATIC;
        r_s1_pen          <= i_penetration_depth;
        r_s1_m1           <= i_mass_first;
        r_s1_m2           <= i_mass_second;
        r_s1_b1           <= i_bounce_first;
        r_s1_b2           <= i_bounce_second;
        r_s1_st1          <= i_fixed_first || (i_mass_first == '0);
        r_s1_st2          <= i_fixed_second || (i_mass_second == '0);
    end

    always_ff @(posedge i_clk) begin
        r_s2_vn   <= cir_pkg::VNW'(w_prod[0]) + cir_pkg::VNW'(w_prod[1])
                   + cir_pkg::VNW'(w_prod[2]);
        r_s2_c    <= cir_pkg::CMW'(r_s1_pen) * cir_pkg::CMW'(r_cf);
        r_s2_k    <= cir_pkg::KW'(512) + cir_pkg::KW'(r_s1_b1) + cir_pkg::KW'(r_s1_b2);
        r_s2_m1   <= r_s1_m1;
        r_s2_m2   <= r_s1_m2;
        r_s2_st1  <= r_s1_st1;
        r_s2_st2  <= r_s1_st2;
        r_s2_side <= r_s1_side;
    end

    assign w_negvn = cir_pkg::VNW'(-r_s2_vn);
    assign w_jfull = (JPW'(w_negvn[cir_pkg::NEGW-1:0]) * JPW'(r_s2_k) + JPW'(4096)) >> 13;
    assign w_res   = !(r_s2_st1 && r_s2_st2) && !(r_s2_vn > 0);

    always_comb begin
        if (r_s2_st1 && r_s2_st2) begin
            w_oc = cir_pkg::OC_STATIC;
        end else if (r_s2_vn > 0) begin
            w_oc = cir_pkg::OC_SEPARATING;
        end else begin
            w_oc = cir_pkg::OC_RESOLVED;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_j <= w_res ? w_jfull[JW-1:0] : '0;
        r_s3_c <= w_res ? JW'(r_s2_c) : '0;
        r_s3_num1 <= r_s2_st1 ? DNW'(0) : (r_s2_st2 ? DNW'(1) : DNW'(r_s2_m2));
        r_s3_num2 <= r_s2_st2 ? DNW'(0) : (r_s2_st1 ? DNW'(1) : DNW'(r_s2_m1));
        r_s3_den  <= (r_s2_st1 || r_s2_st2) ? DNW'(1) : (DNW'(r_s2_m1) + DNW'(r_s2_m2));
        r_s3_side.n       <= r_s2_side.n;
        r_s3_side.v1      <= r_s2_side.v1;
        r_s3_side.v2      <= r_s2_side.v2;
        r_s3_side.p1      <= r_s2_side.p1;
        r_s3_side.p2      <= r_s2_side.p2;
        r_s3_side.outcome <= w_oc;
    end

    always_ff @(posedge i_clk) begin
        r_s4_dj1  <= DVW'(r_s3_j) * DVW'(r_s3_num1) + DVW'(r_s3_den >> 1);
        r_s4_dj2  <= DVW'(r_s3_j) * DVW'(r_s3_num2) + DVW'(r_s3_den >> 1);
        r_s4_dc1  <= DVW'(r_s3_c) * DVW'(r_s3_num1) + DVW'(r_s3_den >> 1);
        r_s4_dc2  <= DVW'(r_s3_c) * DVW'(r_s3_num2) + DVW'(r_s3_den >> 1);
        r_s4_den  <= r_s3_den;
        r_s4_side <= r_s3_side;
    end

    cir_div_pipe u_div_j1 (.i_clk(i_clk), .i_dividend(r_s4_dj1), .i_divisor(r_s4_den),
                           .o_quot(w_qj1));
    cir_div_pipe u_div_j2 (.i_clk(i_clk), .i_dividend(r_s4_dj2), .i_divisor(r_s4_den),
                           .o_quot(w_qj2));
    cir_div_pipe u_div_c1 (.i_clk(i_clk), .i_dividend(r_s4_dc1), .i_divisor(r_s4_den),
                           .o_quot(w_qc1));
    cir_div_pipe u_div_c2 (.i_clk(i_clk), .i_dividend(r_s4_dc2), .i_divisor(r_s4_den),
                           .o_quot(w_qc2));

    assign w_share = {w_qj1, w_qj2, w_qc1, w_qc2};

    always_ff @(posedge i_clk) begin
        r_sd[0] <= r_s4_side;
        for (int i = 1; i < JW; i++) begin
            r_sd[i] <= r_sd[i-1];
        end
        r_oca <= r_sd[JW-1].outcome;
        r_ocb <= r_oca;
    end

    for (genvar a = 0; a < 3; a++) begin : g_upd
        cir_upd_lane u_upd (
            .i_clk   (i_clk),
            .i_n     (r_sd[JW-1].n[a*NW +: NW]),
            .i_v1    (r_sd[JW-1].v1[a*CW +: CW]),
            .i_v2    (r_sd[JW-1].v2[a*CW +: CW]),
            .i_p1    (r_sd[JW-1].p1[a*CW +: CW]),
            .i_p2    (r_sd[JW-1].p2[a*CW +: CW]),
            .i_share (w_share),
            .o_v1    (w_nv1[a]),
            .o_v2    (w_nv2[a]),
            .o_p1    (w_np1[a]),
            .o_p2    (w_np2[a])
        );
    end

    assign o_valid               = r_vld[LAT-1];
    assign o_new_velocity_first  = {w_nv1[2], w_nv1[1], w_nv1[0]};
    assign o_new_velocity_second = {w_nv2[2], w_nv2[1], w_nv2[0]};
    assign o_new_position_first  = {w_np1[2], w_np1[1], w_np1[0]};
    assign o_new_position_second = {w_np2[2], w_np2[1], w_np2[0]};
    assign o_outcome             = r_ocb;

endmodule

// ----- rtl/cir_checker.sv -----
module cir_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [3*cir_pkg::CW-1:0]     i_velocity_first,
    input logic [3*cir_pkg::CW-1:0]     i_position_second,
    input logic                         o_valid,
    input logic [3*cir_pkg::CW-1:0]     o_new_velocity_first,
    input logic [3*cir_pkg::CW-1:0]     o_new_position_second,
    input logic [1:0]                   o_outcome
);

    localparam int LAT = cir_pkg::LAT;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_beat_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without a start");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outcome != 2'd3))
        else $error("outcome out of range");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != cir_pkg::OC_RESOLVED)) |->
            ((o_new_velocity_first == $past(i_velocity_first, LAT))
             && (o_new_position_second == $past(i_position_second, LAT))))
        else $error("unresolved contact altered");

endmodule

bind contact_impulse_resolver_core cir_checker u_cir_checker (.*);
